// ----- hdl/kdsa_pkg.sv -----
// Shared constants, types and helpers for the keyboard distance alignment core.
// No dependencies; every other file in hdl/ except kdsa_ram imports this package.
package kdsa_pkg;

	localparam int MAX_SEQ   = 512;
	localparam int KEY_CODES = 256;
	localparam int KEY_DIM   = 32;

	localparam int REQ_W       = 2;
	localparam int CODE_W      = 8;
	localparam int FIELD_POS_W = 5;
	localparam int SPAN_W      = 5;
	localparam int OUT_W       = 16;

	localparam int ADDR_W    = (MAX_SEQ > 1) ? $clog2(MAX_SEQ) : 1;
	localparam int LEN_W     = $clog2(MAX_SEQ + 1);
	localparam int KEY_IDX_W = (KEY_CODES > 1) ? $clog2(KEY_CODES) : 1;
	localparam int KEY_POS_W = $clog2(KEY_DIM);
	localparam int GAP_W     = SPAN_W + 1;
	localparam int SCORE_W   = $clog2(2 * MAX_SEQ * (2 ** SPAN_W)) + 2;
	localparam int CALC_W    = SCORE_W + 1;
	localparam int OUT_MAX   = 2 ** (OUT_W - 1) - 1;
	localparam int OUT_MIN   = -(2 ** (OUT_W - 1));

	localparam logic [REQ_W-1:0] REQ_KEY   = 2'd0;
	localparam logic [REQ_W-1:0] REQ_APP_X = 2'd1;
	localparam logic [REQ_W-1:0] REQ_APP_Y = 2'd2;
	localparam logic [REQ_W-1:0] REQ_SCORE = 2'd3;

	typedef logic signed [SCORE_W-1:0] score_t;
	typedef logic signed [CALC_W-1:0]  calc_t;
	typedef logic signed [OUT_W-1:0]   out_score_t;

	typedef struct packed {
		logic [KEY_POS_W-1:0] row;
		logic [KEY_POS_W-1:0] col;
	} key_pos_t;

	typedef enum logic [7:0] {
		ST_IDLE  = 8'b0000_0001,
		ST_INIT  = 8'b0000_0010,
		ST_ROW_A = 8'b0000_0100,
		ST_ROW_K = 8'b0000_1000,
		ST_ROW_L = 8'b0001_0000,
		ST_CELL  = 8'b0010_0000,
		ST_DRAIN = 8'b0100_0000,
		ST_FIN   = 8'b1000_0000
	} state_t;

	typedef struct packed {
		logic              vld_s1;
		logic [ADDR_W-1:0] idx_s1;
		logic              row_load;
		score_t            row0_old;
		score_t            row0_new;
	} cell_ctl_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		score_t            data;
	} row_wr_t;

	function automatic out_score_t sat_out(score_t v);
		out_score_t r;
		if (int'(v) > OUT_MAX) begin
			r = OUT_W'(OUT_MAX);
		end else if (int'(v) < OUT_MIN) begin
			r = OUT_W'(OUT_MIN);
		end else begin
			r = OUT_W'(v);
		end
		return r;
	endfunction

endpackage

// ----- hdl/kdsa_req_if.sv -----
// Request channel: valid/ready plus one request item.
// Depends on kdsa_pkg.
interface kdsa_req_if import kdsa_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [REQ_W-1:0]       req_type;
	logic [CODE_W-1:0]      char_code;
	logic [FIELD_POS_W-1:0] key_row;
	logic [FIELD_POS_W-1:0] key_col;

	modport source (output valid, req_type, char_code, key_row, key_col, input ready);
	modport sink (input valid, req_type, char_code, key_row, key_col, output ready);
endinterface

// ----- hdl/kdsa_res_if.sv -----
// Result channel: valid/ready plus score and overflow flag.
// Depends on kdsa_pkg.
interface kdsa_res_if import kdsa_pkg::*; ();
	logic       valid;
	logic       ready;
	out_score_t score;
	logic       overflow;

	modport source (output valid, score, overflow, input ready);
	modport sink (input valid, score, overflow, output ready);
endinterface

// ----- hdl/kdsa_cfg_if.sv -----
// Configuration write channel carrying the key span register.
// Depends on kdsa_pkg.
interface kdsa_cfg_if import kdsa_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [SPAN_W-1:0] key_span;

	modport source (output valid, key_span, input ready);
	modport sink (input valid, key_span, output ready);
endinterface

// ----- hdl/kdsa_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module kdsa_ram #(
	parameter int DEPTH = 512,
	parameter int WIDTH = 8,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- hdl/kdsa_key_table.sv -----
// Character code to key position table with per-entry valid bits.
// Depends on kdsa_pkg; unloaded and out-of-range codes read as position 0,0.
module kdsa_key_table import kdsa_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   wr_en,
	input  logic [CODE_W-1:0]      wr_code,
	input  logic [FIELD_POS_W-1:0] wr_row,
	input  logic [FIELD_POS_W-1:0] wr_col,
	input  logic [CODE_W-1:0]      rd_code,
	output key_pos_t               rd_pos
);

	key_pos_t               mem [KEY_CODES];
	logic [KEY_CODES-1:0]   vld_q;
	key_pos_t               rd_q;
	logic                   rd_vld_q;
	logic                   wr_ok;
	logic                   rd_ok;
	logic [KEY_IDX_W-1:0]   wr_idx;
	logic [KEY_IDX_W-1:0]   rd_idx;
	key_pos_t               wr_pos;

	function automatic logic [KEY_POS_W-1:0] clamp_pos(logic [FIELD_POS_W-1:0] p);
		return (int'(p) >= KEY_DIM) ? KEY_POS_W'(KEY_DIM - 1) : KEY_POS_W'(p);
	endfunction

	assign wr_ok      = wr_en && (int'(wr_code) < KEY_CODES);
	assign rd_ok      = int'(rd_code) < KEY_CODES;
	assign wr_idx     = KEY_IDX_W'(wr_code);
	assign rd_idx     = KEY_IDX_W'(rd_code);
	assign wr_pos.row = clamp_pos(wr_row);
	assign wr_pos.col = clamp_pos(wr_col);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_ok) begin
				vld_q[wr_idx] <= 1'b1;
			end
			rd_vld_q <= rd_ok && vld_q[rd_idx];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_ok) begin
			mem[wr_idx] <= wr_pos;
		end
		rd_q <= mem[rd_idx];
	end

	assign rd_pos = rd_vld_q ? rd_q : '0;

endmodule

// ----- hdl/kdsa_cell.sv -----
// Score cell pipeline: key distance and diagonal/up candidates, then left recurrence.
// Depends on kdsa_pkg; fed by the row and sequence RAM read data and the key table.
module kdsa_cell import kdsa_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  cell_ctl_t         ctl,
	input  score_t            gap,
	input  key_pos_t          key_a,
	input  logic [CODE_W-1:0] code_a,
	input  logic [CODE_W-1:0] code_b,
	input  score_t            up,
	input  key_pos_t          key_b,
	output row_wr_t           wr,
	output logic              busy
);

	logic              vld_s2;
	logic              vld_s3;
	logic [ADDR_W-1:0] idx_s2;
	logic [ADDR_W-1:0] idx_s3;
	logic [CODE_W-1:0] code_b_s2;
	score_t            up_s2;
	score_t            t_s3;
	score_t            diag_q;
	score_t            left_q;
	logic [KEY_POS_W-1:0] dr;
	logic [KEY_POS_W-1:0] dc;
	logic [KEY_POS_W-1:0] key_dist;
	calc_t             cand;
	calc_t             upg;
	calc_t             lg;
	calc_t             v;

	function automatic logic [KEY_POS_W-1:0] abs_diff(logic [KEY_POS_W-1:0] a,
			logic [KEY_POS_W-1:0] b);
		return (a >= b) ? a - b : b - a;
	endfunction

	assign dr       = abs_diff(key_a.row, key_b.row);
	assign dc       = abs_diff(key_a.col, key_b.col);
	assign key_dist = (code_a == code_b_s2) ? '0 : ((dr > dc) ? dr : dc);
	assign cand     = calc_t'(diag_q) + calc_t'(gap) - calc_t'(key_dist);
	assign upg      = calc_t'(up_s2) - calc_t'(gap);
	assign lg       = calc_t'(left_q) - calc_t'(gap);
	assign v        = (lg > calc_t'(t_s3)) ? lg : calc_t'(t_s3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s2 <= ctl.vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		idx_s2    <= ctl.idx_s1;
		code_b_s2 <= code_b;
		up_s2     <= up;
		idx_s3    <= idx_s2;
		t_s3      <= SCORE_W'((upg > cand) ? upg : cand);
		if (ctl.row_load) begin
			diag_q <= ctl.row0_old;
			left_q <= ctl.row0_new;
		end else begin
			if (vld_s2) begin
				diag_q <= up_s2;
			end
			if (vld_s3) begin
				left_q <= SCORE_W'(v);
			end
		end
	end

	assign wr.en   = vld_s3;
	assign wr.addr = idx_s3;
	assign wr.data = SCORE_W'(v);
	assign busy    = vld_s2 || vld_s3;

endmodule

// ----- hdl/keyboard_distance_sequence_alignment_core.sv -----
// Top level of the keyboard distance global alignment core: sequencer, memories, cell.
// Depends on kdsa_pkg, the channel interfaces, kdsa_ram, kdsa_key_table and kdsa_cell.
//
//  channel | dir | handshake    | payload
//  cfg     | in  | valid/ready  | key_span
//  req     | in  | valid/ready  | req_type, char_code, key_row, key_col
//  res     | out | valid/ready  | score, overflow
//
// Key loads and appends do not leave the idle state. A score request with lengths n and
// m > 0 holds the input while an INIT sweep seeds the DP row; each row then spends ROW_A,
// ROW_K and ROW_L on its character and key, CELL on m issuing cells and DRAIN until the cell
// pipeline is empty. With m = 0 each row passes through ROW_A only.
// Reset clears the key table valid bits at once; no clearing pass. A waiting result
// does not stop loads; a finished score holds until the result register is free.
module keyboard_distance_sequence_alignment_core import kdsa_pkg::*; (
	input logic         clk,
	input logic         arst_n,
	kdsa_cfg_if.sink    cfg,
	kdsa_req_if.sink    req,
	kdsa_res_if.source  res
);

	state_t             st_q;
	logic [SPAN_W-1:0]  span_q;
	logic [LEN_W-1:0]   len_x_q;
	logic [LEN_W-1:0]   len_y_q;
	logic               drop_q;
	logic [LEN_W-1:0]   n_q;
	logic [LEN_W-1:0]   m_q;
	logic               ovf_q;
	logic [ADDR_W-1:0]  i_q;
	logic [ADDR_W-1:0]  j_q;
	logic               vld_s1;
	logic [ADDR_W-1:0]  idx_s1;
	score_t             acc_q;
	score_t             row0_q;
	score_t             last_q;
	logic [CODE_W-1:0]  code_a_q;
	key_pos_t           key_a_q;
	logic               res_valid_q;
	out_score_t         res_score_q;
	logic               res_ovf_q;

	logic               req_acc;
	logic               is_key;
	logic               is_app_x;
	logic               is_app_y;
	logic               is_score;
	logic               app_x_ok;
	logic               app_y_ok;
	logic               i_last;
	logic               j_last;
	logic               res_free;
	logic [GAP_W-1:0]   gap;
	score_t             gap_sc;
	score_t             init_val;
	logic [CODE_W-1:0]  x_rdata;
	logic [CODE_W-1:0]  y_rdata;
	score_t             row_rdata;
	key_pos_t           key_rd;
	logic [CODE_W-1:0]  key_rd_code;
	logic               row_we;
	logic [ADDR_W-1:0]  row_waddr;
	score_t             row_wdata;
	cell_ctl_t          cell_ctl;
	row_wr_t            cell_wr;
	logic               cell_busy;

	assign req.ready = (st_q == ST_IDLE);
	assign cfg.ready = 1'b1;
	assign req_acc   = req.valid && req.ready;

	always_comb begin
		is_key   = 1'b0;
		is_app_x = 1'b0;
		is_app_y = 1'b0;
		is_score = 1'b0;
		unique case (req.req_type)
			REQ_KEY:   is_key   = 1'b1;
			REQ_APP_X: is_app_x = 1'b1;
			REQ_APP_Y: is_app_y = 1'b1;
			REQ_SCORE: is_score = 1'b1;
			default:   is_score = 1'b0;
		endcase
	end

	assign app_x_ok = req_acc && is_app_x && (int'(len_x_q) < MAX_SEQ);
	assign app_y_ok = req_acc && is_app_y && (int'(len_y_q) < MAX_SEQ);
	assign i_last   = (LEN_W'(i_q) + LEN_W'(1)) == n_q;
	assign j_last   = (LEN_W'(j_q) + LEN_W'(1)) == m_q;
	assign res_free = !res_valid_q || res.ready;
	assign gap      = GAP_W'(span_q) + GAP_W'(1);
	assign gap_sc   = score_t'(gap);
	assign init_val = acc_q - gap_sc;

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			span_q      <= '0;
			len_x_q     <= '0;
			len_y_q     <= '0;
			drop_q      <= 1'b0;
			n_q         <= '0;
			m_q         <= '0;
			ovf_q       <= 1'b0;
			i_q         <= '0;
			j_q         <= '0;
			vld_s1      <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				span_q <= cfg.key_span;
			end
			if (res.valid && res.ready) begin
				res_valid_q <= 1'b0;
			end
			if (app_x_ok) begin
				len_x_q <= len_x_q + LEN_W'(1);
			end
			if (app_y_ok) begin
				len_y_q <= len_y_q + LEN_W'(1);
			end
			if (req_acc && (is_app_x || is_app_y) && !app_x_ok && !app_y_ok) begin
				drop_q <= 1'b1;
			end
			vld_s1 <= (st_q == ST_CELL);

			unique case (st_q)
				ST_IDLE: begin
					if (req_acc && is_score) begin
						n_q     <= len_x_q;
						m_q     <= len_y_q;
						ovf_q   <= drop_q;
						len_x_q <= '0;
						len_y_q <= '0;
						drop_q  <= 1'b0;
						i_q     <= '0;
						j_q     <= '0;
						if (len_y_q != '0) begin
							st_q <= ST_INIT;
						end else if (len_x_q != '0) begin
							st_q <= ST_ROW_A;
						end else begin
							st_q <= ST_FIN;
						end
					end
				end
				ST_INIT: begin
					j_q <= j_q + ADDR_W'(1);
					if (j_last) begin
						st_q <= (n_q != '0) ? ST_ROW_A : ST_FIN;
					end
				end
				ST_ROW_A: begin
					if (m_q == '0) begin
						if (i_last) begin
							st_q <= ST_FIN;
						end else begin
							i_q <= i_q + ADDR_W'(1);
						end
					end else begin
						st_q <= ST_ROW_K;
					end
				end
				ST_ROW_K: begin
					st_q <= ST_ROW_L;
				end
				ST_ROW_L: begin
					j_q  <= '0;
					st_q <= ST_CELL;
				end
				ST_CELL: begin
					j_q <= j_q + ADDR_W'(1);
					if (j_last) begin
						st_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!vld_s1 && !cell_busy) begin
						if (i_last) begin
							st_q <= ST_FIN;
						end else begin
							i_q  <= i_q + ADDR_W'(1);
							st_q <= ST_ROW_A;
						end
					end
				end
				ST_FIN: begin
					if (res_free) begin
						res_valid_q <= 1'b1;
						st_q        <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		idx_s1 <= j_q;
		if (st_q == ST_IDLE) begin
			acc_q  <= '0;
			row0_q <= '0;
		end
		if (st_q == ST_INIT) begin
			acc_q <= init_val;
		end
		if (st_q == ST_ROW_A) begin
			row0_q <= row0_q - gap_sc;
		end
		if (st_q == ST_ROW_K) begin
			code_a_q <= x_rdata;
		end
		if (st_q == ST_ROW_L) begin
			key_a_q <= key_rd;
		end
		if (st_q == ST_IDLE) begin
			last_q <= '0;
		end else if (row_we) begin
			last_q <= row_wdata;
		end
		if (st_q == ST_FIN && res_free) begin
			res_score_q <= sat_out((m_q == '0) ? row0_q : last_q);
			res_ovf_q   <= ovf_q;
		end
	end

	assign res.valid    = res_valid_q;
	assign res.score    = res_score_q;
	assign res.overflow = res_ovf_q;

	assign row_we    = (st_q == ST_INIT) || cell_wr.en;
	assign row_waddr = (st_q == ST_INIT) ? j_q : cell_wr.addr;
	assign row_wdata = (st_q == ST_INIT) ? init_val : cell_wr.data;

	assign key_rd_code = (st_q == ST_ROW_K) ? x_rdata : y_rdata;

	assign cell_ctl.vld_s1   = vld_s1;
	assign cell_ctl.idx_s1   = idx_s1;
	assign cell_ctl.row_load = (st_q == ST_ROW_A);
	assign cell_ctl.row0_old = row0_q;
	assign cell_ctl.row0_new = row0_q - gap_sc;

	kdsa_ram #(.DEPTH(MAX_SEQ), .WIDTH(CODE_W)) u_x_ram (
		.clk   (clk),
		.we    (app_x_ok),
		.waddr (ADDR_W'(len_x_q)),
		.wdata (req.char_code),
		.re    (st_q == ST_ROW_A),
		.raddr (i_q),
		.rdata (x_rdata)
	);

	kdsa_ram #(.DEPTH(MAX_SEQ), .WIDTH(CODE_W)) u_y_ram (
		.clk   (clk),
		.we    (app_y_ok),
		.waddr (ADDR_W'(len_y_q)),
		.wdata (req.char_code),
		.re    (st_q == ST_CELL),
		.raddr (j_q),
		.rdata (y_rdata)
	);

	kdsa_ram #(.DEPTH(MAX_SEQ), .WIDTH(SCORE_W)) u_row_ram (
		.clk   (clk),
		.we    (row_we),
		.waddr (row_waddr),
		.wdata (row_wdata),
		.re    (st_q == ST_CELL),
		.raddr (j_q),
		.rdata (row_rdata)
	);

	kdsa_key_table u_key_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (req_acc && is_key),
		.wr_code (req.char_code),
		.wr_row  (req.key_row),
		.wr_col  (req.key_col),
		.rd_code (key_rd_code),
		.rd_pos  (key_rd)
	);

	kdsa_cell u_cell (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (cell_ctl),
		.gap    (gap_sc),
		.key_a  (key_a_q),
		.code_a (code_a_q),
		.code_b (y_rdata),
		.up     (row_rdata),
		.key_b  (key_rd),
		.wr     (cell_wr),
		.busy   (cell_busy)
	);

	a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!arst_n)
		req.ready |-> !(vld_s1 || cell_busy))
		else $error("request taken while cell pipeline busy");

	a_row_port_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!((st_q == ST_INIT) && cell_wr.en))
		else $error("row RAM written by sweep and cell together");

	a_res_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(st_q == ST_FIN))
		else $error("result raised outside finish");

	a_cell_needs_cols: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_CELL) |-> (m_q != '0))
		else $error("cells issued for empty second sequence");

endmodule

// ----- test/tb_keyboard_distance_sequence_alignment_core.sv -----
// Self-checking testbench for the keyboard distance alignment core: a queued request
// driver, a result monitor and a scoring predictor. Depends on kdsa_pkg, the three
// channel interfaces and the core itself.
`timescale 1ns / 100ps

module tb_keyboard_distance_sequence_alignment_core;
	import kdsa_pkg::*;

	localparam int QUIET_LIMIT = 150000;
	localparam int HOLD_CYCLES = 600;
	localparam int SETTLE      = 20;

	typedef enum int {MODE_SEND_SPARSE, MODE_RECV_SPARSE, MODE_NONE} idle_mode_t;

	typedef struct packed {
		logic [REQ_W-1:0]       kind;
		logic [CODE_W-1:0]      code;
		logic [FIELD_POS_W-1:0] row;
		logic [FIELD_POS_W-1:0] col;
	} kd_request_t;

	typedef struct packed {
		out_score_t score;
		logic       overflow;
	} kd_score_t;

	logic clk = 1'b0;
	logic arst_n;

	kdsa_cfg_if cfg_bus ();
	kdsa_req_if req_bus ();
	kdsa_res_if res_bus ();

	keyboard_distance_sequence_alignment_core i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_bus),
		.req    (req_bus),
		.res    (res_bus)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor state
	logic [SPAN_W-1:0]    span_model;
	logic [KEY_POS_W-1:0] key_row_tbl[KEY_CODES] = '{default: '0};
	logic [KEY_POS_W-1:0] key_col_tbl[KEY_CODES] = '{default: '0};
	logic [CODE_W-1:0]    seq_x[$];
	logic [CODE_W-1:0]    seq_y[$];
	logic                 dropped;
	int                   dp_row[0:MAX_SEQ];

	kd_request_t pending_requests[$];
	kd_score_t   expected_scores[$];
	kd_request_t req_on_bus;
	idle_mode_t  idle_mode;
	int          reqs_queued;
	int          reqs_taken;
	int          scores_checked;
	int          mismatches;
	int          quiet_cycles;
	int          hold_left;
	bit          hold_done;

	function automatic int send_idle_pct();
		case (idle_mode)
			MODE_SEND_SPARSE: return 35;
			MODE_RECV_SPARSE: return 56;
			default:          return 0;
		endcase
	endfunction

	function automatic int recv_idle_pct();
		case (idle_mode)
			MODE_SEND_SPARSE: return 56;
			MODE_RECV_SPARSE: return 35;
			default:          return 0;
		endcase
	endfunction

	function automatic logic [KEY_POS_W-1:0] clamp_pos(logic [FIELD_POS_W-1:0] p);
		return (int'(p) >= KEY_DIM) ? KEY_POS_W'(KEY_DIM - 1) : KEY_POS_W'(p);
	endfunction

	function automatic int key_travel(logic [CODE_W-1:0] a, logic [CODE_W-1:0] b);
		int ra, ca, rb, cb, dr, dc;
		if (a == b) begin
			return 0;
		end
		ra = (int'(a) < KEY_CODES) ? int'(key_row_tbl[a]) : 0;
		ca = (int'(a) < KEY_CODES) ? int'(key_col_tbl[a]) : 0;
		rb = (int'(b) < KEY_CODES) ? int'(key_row_tbl[b]) : 0;
		cb = (int'(b) < KEY_CODES) ? int'(key_col_tbl[b]) : 0;
		dr = (ra > rb) ? ra - rb : rb - ra;
		dc = (ca > cb) ? ca - cb : cb - ca;
		return (dr > dc) ? dr : dc;
	endfunction

	function automatic kd_score_t align_expected();
		kd_score_t r;
		int        gap, diag, up, best, total, i, j;
		gap = int'(span_model) + 1;
		for (j = 0; j <= seq_y.size(); j++) begin
			dp_row[j] = -gap * j;
		end
		for (i = 1; i <= seq_x.size(); i++) begin
			diag = dp_row[0];
			dp_row[0] = -gap * i;
			for (j = 1; j <= seq_y.size(); j++) begin
				up = dp_row[j];
				best = diag + gap - key_travel(seq_x[i-1], seq_y[j-1]);
				if (up - gap > best) begin
					best = up - gap;
				end
				if (dp_row[j-1] - gap > best) begin
					best = dp_row[j-1] - gap;
				end
				diag = up;
				dp_row[j] = best;
			end
		end
		total = dp_row[seq_y.size()];
		if (total > OUT_MAX) begin
			total = OUT_MAX;
		end
		if (total < OUT_MIN) begin
			total = OUT_MIN;
		end
		r.score = out_score_t'(total);
		r.overflow = dropped;
		return r;
	endfunction

	task automatic apply_request(input kd_request_t r);
		case (r.kind)
			REQ_KEY: begin
				if (int'(r.code) < KEY_CODES) begin
					key_row_tbl[r.code] = clamp_pos(r.row);
					key_col_tbl[r.code] = clamp_pos(r.col);
				end
			end
			REQ_APP_X: begin
				if (seq_x.size() < MAX_SEQ) begin
					seq_x.push_back(r.code);
				end else begin
					dropped = 1'b1;
				end
			end
			REQ_APP_Y: begin
				if (seq_y.size() < MAX_SEQ) begin
					seq_y.push_back(r.code);
				end else begin
					dropped = 1'b1;
				end
			end
			default: begin
				expected_scores.push_back(align_expected());
				seq_x.delete();
				seq_y.delete();
				dropped = 1'b0;
			end
		endcase
	endtask

	task automatic note_mismatch(input string what, input int want, input int got);
		if (mismatches < 10) begin
			$display("%0t: %s mismatch: expected %0d, got %0d", $realtime, what, want, got);
		end
		mismatches++;
	endtask

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_bus.valid <= 1'b0;
			req_bus.req_type <= '0;
			req_bus.char_code <= '0;
			req_bus.key_row <= '0;
			req_bus.key_col <= '0;
		end else begin
			if (req_bus.valid && req_bus.ready) begin
				apply_request(req_on_bus);
				reqs_taken++;
			end
			if (!req_bus.valid || req_bus.ready) begin
				if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct()) begin
					req_on_bus = pending_requests.pop_front();
					req_bus.valid <= 1'b1;
					req_bus.req_type <= req_on_bus.kind;
					req_bus.char_code <= req_on_bus.code;
					req_bus.key_row <= req_on_bus.row;
					req_bus.key_col <= req_on_bus.col;
				end else begin
					req_bus.valid <= 1'b0;
				end
			end
		end
	end

	// result monitor; holds off once for a long stretch when idling stops
	always @(posedge clk or negedge arst_n) begin
		kd_score_t want;
		if (!arst_n) begin
			res_bus.ready <= 1'b0;
			hold_left = 0;
			hold_done = 1'b0;
		end else begin
			if (res_bus.valid && res_bus.ready) begin
				if (expected_scores.size() == 0) begin
					note_mismatch("unexpected score", 0, int'(res_bus.score));
				end else begin
					want = expected_scores.pop_front();
					if (res_bus.score !== want.score) begin
						note_mismatch("score", int'(want.score), int'(res_bus.score));
					end
					if (res_bus.overflow !== want.overflow) begin
						note_mismatch("overflow", int'(want.overflow), int'(res_bus.overflow));
					end
					scores_checked++;
				end
			end
			if (idle_mode == MODE_NONE && !hold_done) begin
				hold_left = HOLD_CYCLES;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_bus.ready <= 1'b0;
			end else begin
				res_bus.ready <= ($urandom_range(99) >= recv_idle_pct());
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (req_bus.valid && req_bus.ready) || (res_bus.valid && res_bus.ready)
				|| (cfg_bus.valid && cfg_bus.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Watchdog: no handshake for %0d cycles", QUIET_LIMIT);
			$display("Test completed with failures");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic logic [CODE_W-1:0] pick_code();
		if ($urandom_range(9) < 7) begin
			return CODE_W'($urandom_range(8'h68, 8'h61));
		end
		return CODE_W'($urandom_range(255));
	endfunction

	task automatic push_request(input logic [REQ_W-1:0] kind, input int code,
			input int row, input int col);
		kd_request_t r;
		r.kind = kind;
		r.code = CODE_W'(code);
		r.row = FIELD_POS_W'(row);
		r.col = FIELD_POS_W'(col);
		pending_requests.push_back(r);
		reqs_queued++;
	endtask

	task automatic queue_job(input int nx, input int ny);
		int ax, ay;
		repeat ($urandom_range(2)) begin
			push_request(REQ_KEY, pick_code(), $urandom_range(31), $urandom_range(31));
		end
		ax = 0;
		ay = 0;
		while (ax < nx || ay < ny) begin
			if (ay >= ny || (ax < nx && $urandom_range(1) == 1)) begin
				push_request(REQ_APP_X, pick_code(), $urandom_range(31), $urandom_range(31));
				ax++;
			end else begin
				push_request(REQ_APP_Y, pick_code(), $urandom_range(31), $urandom_range(31));
				ay++;
			end
		end
		push_request(REQ_SCORE, $urandom_range(255), $urandom_range(31), $urandom_range(31));
	endtask

	task automatic queue_random(input int budget);
		int stop_at, pick;
		stop_at = reqs_queued + budget;
		while (reqs_queued < stop_at) begin
			pick = $urandom_range(23);
			if (pick == 0) begin
				push_request(REQ_SCORE, $urandom_range(255), $urandom_range(31), $urandom_range(31));
			end else if (pick == 1) begin
				repeat ($urandom_range(4, 1)) begin
					push_request(REQ_KEY, $urandom_range(255), $urandom_range(31),
						$urandom_range(31));
				end
			end else if (pick == 2) begin
				queue_job($urandom_range(40, 10), $urandom_range(40, 10));
			end else begin
				queue_job($urandom_range(8), $urandom_range(8));
			end
		end
	endtask

	task automatic wait_drained();
		do @(posedge clk); while (reqs_taken != reqs_queued || expected_scores.size() != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_key_span(input logic [SPAN_W-1:0] v);
		@(posedge clk);
		cfg_bus.valid <= 1'b1;
		cfg_bus.key_span <= v;
		do @(posedge clk); while (!cfg_bus.ready);
		cfg_bus.valid <= 1'b0;
		span_model = v;
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_bus.valid = 1'b0;
		cfg_bus.key_span = '0;
		req_bus.valid = 1'b0;
		req_bus.req_type = '0;
		req_bus.char_code = '0;
		req_bus.key_row = '0;
		req_bus.key_col = '0;
		res_bus.ready = 1'b0;
		span_model = '0;
		dropped = 1'b0;
		idle_mode = MODE_SEND_SPARSE;
		reqs_queued = 0;
		reqs_taken = 0;
		scores_checked = 0;
		mismatches = 0;
		quiet_cycles = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		write_key_span(SPAN_W'(7));
		push_request(REQ_SCORE, 0, 0, 0);
		push_request(REQ_KEY, 8'hFF, 31, 31);
		push_request(REQ_KEY, 8'h00, 0, 31);
		push_request(REQ_KEY, 8'h41, 31, 0);
		push_request(REQ_APP_X, 8'hFF, 0, 0);
		push_request(REQ_APP_X, 8'h00, 0, 0);
		push_request(REQ_SCORE, 8'hFF, 31, 31);
		push_request(REQ_APP_Y, 8'h41, 0, 0);
		push_request(REQ_APP_Y, 8'h7E, 0, 0);
		push_request(REQ_SCORE, 0, 0, 0);
		push_request(REQ_APP_X, 8'h41, 0, 0);
		push_request(REQ_APP_X, 8'hFF, 0, 0);
		push_request(REQ_APP_Y, 8'h41, 0, 0);
		push_request(REQ_APP_Y, 8'h00, 0, 0);
		push_request(REQ_APP_Y, 8'h33, 0, 0);
		push_request(REQ_SCORE, 0, 0, 0);
		// reload a key so a later lookup sees the new place
		push_request(REQ_KEY, 8'h41, 0, 0);
		push_request(REQ_APP_X, 8'h41, 0, 0);
		push_request(REQ_APP_Y, 8'hFF, 0, 0);
		push_request(REQ_SCORE, 0, 0, 0);
		wait_drained();

		write_key_span(SPAN_W'(31));
		queue_random(130);
		wait_drained();

		idle_mode = MODE_RECV_SPARSE;
		write_key_span(SPAN_W'(0));
		queue_random(130);
		wait_drained();

		write_key_span(SPAN_W'($urandom_range(30, 1)));
		idle_mode = MODE_NONE;
		queue_random(130);
		wait_drained();

		$display("Summary: %0d requests accepted, %0d scores compared", reqs_taken,
			scores_checked);
		$display("Key spans 0, 7, 31 and one random; empty sides, key reloads, long result stall");
		if (mismatches == 0 && expected_scores.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
